@@ sv/lhbp_pkg.sv @@
// ----------------------------------------------------------------------------
// lhbp_pkg
// Shared types, constants and helpers for the local history branch predictor.
// ----------------------------------------------------------------------------
package lhbp_pkg;

   // default sizes of the table and of the branch address
   localparam int DEF_MAX_INDEX_BITS = 10;
   localparam int DEF_ADDRESS_BITS   = 12;

   // index_bits control register
   localparam int               CFG_W     = 4;
   localparam logic [CFG_W-1:0] CFG_RESET = 4'd3;

   // per-entry history and counter geometry
   localparam int HIST_W   = 2;
   localparam int CTR_W    = 2;
   localparam int NUM_CTRS = 1 << HIST_W;
   localparam int ROW_W    = NUM_CTRS * CTR_W;

   localparam logic [CTR_W-1:0] CTR_MAX = '1;
   localparam logic [CTR_W-1:0] CTR_MIN = '0;

   // word address offset of a byte address
   localparam int ADDR_SHIFT = 2;

   // entries in the queue between front and back, power of two
   localparam int QUEUE_DEPTH = 2;

   // back end sequencer
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ
   } back_state_type;

   // queue occupancy seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // saturating 2-bit counter step
   function automatic logic [CTR_W-1:0] ctr_update(input logic [CTR_W-1:0] ctr,
                                                   input logic             taken);
      logic [CTR_W-1:0] result;
      result = ctr;
      if (taken) begin
         if (ctr != CTR_MAX) result = ctr + 1'b1;
      end else begin
         if (ctr != CTR_MIN) result = ctr - 1'b1;
      end
      return result;
   endfunction

endpackage

@@ sv/lhbp_ram.sv @@
// ----------------------------------------------------------------------------
// lhbp_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lhbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/lhbp_queue.sv @@
// ----------------------------------------------------------------------------
// lhbp_queue
// Small FIFO that decouples the request front end from the table back end.
// ----------------------------------------------------------------------------
module lhbp_queue #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [WIDTH-1:0]            push_data,
   input  logic                        pop,
   output logic [WIDTH-1:0]            head_data,
   output lhbp_pkg::queue_status_type  status
);
   import lhbp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   // occupancy flags
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   // pointer and count next values
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = PTR_W'(wr_ptr_ff + 1'b1);
      if (do_pop)  rd_ptr_in = PTR_W'(rd_ptr_ff + 1'b1);
      if (do_push && !do_pop) count_in = CNT_W'(count_ff + 1'b1);
      if (do_pop && !do_push) count_in = CNT_W'(count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ptr_ff] <= push_data;
   end

   assign head_data = slots_ff[rd_ptr_ff];

endmodule

@@ sv/lhbp_front.sv @@
// ----------------------------------------------------------------------------
// lhbp_front
// Request front end: holds the index_bits register, turns the branch address
// into a table entry index and pushes the transaction into the queue.
// ----------------------------------------------------------------------------
module lhbp_front #(
   parameter int MAX_INDEX_BITS = lhbp_pkg::DEF_MAX_INDEX_BITS,
   parameter int ADDRESS_BITS   = lhbp_pkg::DEF_ADDRESS_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ADDRESS_BITS-1:0]       req_branch_address,
   input  logic                          req_taken,
   input  logic                          csr_wr_en,
   input  logic [lhbp_pkg::CFG_W-1:0]    csr_wr_data,
   input  lhbp_pkg::queue_status_type    q_status,
   input  logic                          clearing,
   output logic                          push,
   output logic [MAX_INDEX_BITS:0]       push_data
);
   import lhbp_pkg::*;

   logic [CFG_W-1:0]          index_bits_ff, index_bits_in;
   logic [MAX_INDEX_BITS-1:0] word_idx;
   logic [MAX_INDEX_BITS-1:0] idx_mask;
   logic [MAX_INDEX_BITS-1:0] entry;

   // index_bits register
   always_comb begin
      index_bits_in = index_bits_ff;
      if (csr_wr_en) index_bits_in = csr_wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) index_bits_ff <= CFG_RESET;
      else       index_bits_ff <= index_bits_in;
   end

   // word address bits, zero above the top of the address
   for (genvar i = 0; i < MAX_INDEX_BITS; i++) begin : g_word
      if (i + ADDR_SHIFT < ADDRESS_BITS) begin : g_bit
         assign word_idx[i] = req_branch_address[i + ADDR_SHIFT];
      end else begin : g_zero
         assign word_idx[i] = 1'b0;
      end
   end

   // low index_bits mask, values above the table size keep every bit
   always_comb begin
      for (int i = 0; i < MAX_INDEX_BITS; i++) begin
         idx_mask[i] = (int'(index_bits_ff) > i);
      end
   end

   assign entry = word_idx & idx_mask;

   // accept into the queue when it is not full and the tables are cleared
   assign req_ready = !q_status.full && !clearing;
   assign push      = req_valid && req_ready;
   assign push_data = {entry, req_taken};

endmodule

@@ sv/lhbp_back.sv @@
// ----------------------------------------------------------------------------
// lhbp_back
// Table back end: clears the tables after reset, then for each queued
// transaction reads history and counter row, updates both and registers the
// prediction result.
// ----------------------------------------------------------------------------
module lhbp_back #(
   parameter int MAX_INDEX_BITS = lhbp_pkg::DEF_MAX_INDEX_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [MAX_INDEX_BITS:0]       head_data,
   input  lhbp_pkg::queue_status_type    q_status,
   output logic                          pop,
   output logic                          clearing,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_predicted_taken,
   output logic                          rsp_mispredicted,
   output logic [MAX_INDEX_BITS-1:0]     rsp_entry_index,
   output logic [lhbp_pkg::HIST_W-1:0]   rsp_history_before,
   output logic [lhbp_pkg::CTR_W-1:0]    rsp_counter_before,
   output logic [lhbp_pkg::CTR_W-1:0]    rsp_counter_after
);
   import lhbp_pkg::*;

   localparam int ENTRIES = 1 << MAX_INDEX_BITS;

   back_state_type            state_ff, state_in;
   logic [MAX_INDEX_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic [MAX_INDEX_BITS-1:0] entry_ff, entry_in;
   logic                      taken_ff, taken_in;

   logic [MAX_INDEX_BITS-1:0] head_entry;
   logic                      head_taken;

   logic                      ram_we;
   logic [MAX_INDEX_BITS-1:0] ram_waddr;
   logic [MAX_INDEX_BITS-1:0] ram_raddr;
   logic [HIST_W-1:0]         hist_wdata, hist_rdata;
   logic [ROW_W-1:0]          row_wdata, row_rdata, row_new;

   logic [CTR_W-1:0]          ctr_before, ctr_after;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      pred_ff, mispred_ff;
   logic [MAX_INDEX_BITS-1:0] out_entry_ff;
   logic [HIST_W-1:0]         out_hist_ff;
   logic [CTR_W-1:0]          out_before_ff, out_after_ff;

   assign head_entry = head_data[MAX_INDEX_BITS:1];
   assign head_taken = head_data[0];

   // history and counter tables, one row per entry
   lhbp_ram #(
      .WIDTH (HIST_W),
      .DEPTH (ENTRIES)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (hist_wdata),
      .rd_addr (ram_raddr),
      .rd_data (hist_rdata)
   );

   lhbp_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ENTRIES)
   ) u_ctr_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (row_wdata),
      .rd_addr (ram_raddr),
      .rd_data (row_rdata)
   );

   // counter selected by the history and its update
   assign ctr_before = row_rdata[hist_rdata*CTR_W +: CTR_W];
   assign ctr_after  = ctr_update(ctr_before, taken_ff);

   always_comb begin
      for (int k = 0; k < NUM_CTRS; k++) begin
         row_new[k*CTR_W +: CTR_W] = (HIST_W'(k) == hist_rdata) ? ctr_after
                                                                 : row_rdata[k*CTR_W +: CTR_W];
      end
   end

   // sequencer: clear sweep, then read and write back one transaction at a time
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      entry_in    = entry_ff;
      taken_in    = taken_ff;
      pop         = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = clr_addr_ff;
      ram_raddr   = head_entry;
      hist_wdata  = '0;
      row_wdata   = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            clr_addr_in = MAX_INDEX_BITS'(clr_addr_ff + 1'b1);
            if (clr_addr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (!q_status.empty && (!rsp_valid_ff || rsp_ready)) begin
               pop      = 1'b1;
               entry_in = head_entry;
               taken_in = head_taken;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            ram_we     = 1'b1;
            ram_waddr  = entry_ff;
            hist_wdata = {hist_rdata[HIST_W-2:0], taken_ff};
            row_wdata  = row_new;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // transaction being worked on
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      taken_ff <= taken_in;
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_READ) rsp_valid_in = 1'b1;
      else if (rsp_ready)      rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         pred_ff       <= ctr_before[CTR_W-1];
         mispred_ff    <= ctr_before[CTR_W-1] ^ taken_ff;
         out_entry_ff  <= entry_ff;
         out_hist_ff   <= hist_rdata;
         out_before_ff <= ctr_before;
         out_after_ff  <= ctr_after;
      end
   end

   assign clearing            = (state_ff == ST_CLEAR);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_predicted_taken = pred_ff;
   assign rsp_mispredicted    = mispred_ff;
   assign rsp_entry_index     = out_entry_ff;
   assign rsp_history_before  = out_hist_ff;
   assign rsp_counter_before  = out_before_ff;
   assign rsp_counter_after   = out_after_ff;

   // result register is always free when a new result is loaded
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_ff)
      else $error("result register overwritten");

   // no result while the tables are being cleared
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!rsp_valid_ff && !pop))
      else $error("activity during table clear");

   // counter moves in the direction of the outcome
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |->
         (taken_ff ? (ctr_after >= ctr_before) : (ctr_after <= ctr_before)))
      else $error("counter moved against the outcome");

   // a pop is always followed by the write back cycle
   assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == ST_READ))
      else $error("popped transaction not processed");

endmodule

@@ sv/local_history_branch_predictor_top.sv @@
// ----------------------------------------------------------------------------
// local_history_branch_predictor_top
// Two-level local branch predictor with 2-bit per-entry history.
//
//   channel | ports          | direction | contents
//   --------+----------------+-----------+--------------------------------------
//   request | req_*          | in        | resolved branch address and outcome
//   result  | rsp_*          | out       | prediction, index, history, counters
//   control | csr_wr_*       | in        | index_bits register write
//
// A transaction is popped in ST_IDLE, where the history and counter row of
// its entry are read, then in ST_READ both are written back and the result
// register is loaded: a read-modify-write through the registered-read tables.
// After reset the tables are cleared one entry per cycle, during which
// req_ready is low.
// A two-entry queue lets requests be taken while the back end waits on a
// stalled result channel; the result register holds until rsp_ready.
// ----------------------------------------------------------------------------
module local_history_branch_predictor_top #(
   parameter int MAX_INDEX_BITS = lhbp_pkg::DEF_MAX_INDEX_BITS,
   parameter int ADDRESS_BITS   = lhbp_pkg::DEF_ADDRESS_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ADDRESS_BITS-1:0]       req_branch_address,
   input  logic                          req_taken,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_predicted_taken,
   output logic                          rsp_mispredicted,
   output logic [MAX_INDEX_BITS-1:0]     rsp_entry_index,
   output logic [lhbp_pkg::HIST_W-1:0]   rsp_history_before,
   output logic [lhbp_pkg::CTR_W-1:0]    rsp_counter_before,
   output logic [lhbp_pkg::CTR_W-1:0]    rsp_counter_after,
   input  logic                          csr_wr_en,
   input  logic [lhbp_pkg::CFG_W-1:0]    csr_wr_data
);
   import lhbp_pkg::*;

   queue_status_type        q_status;
   logic                    push, pop, clearing;
   logic [MAX_INDEX_BITS:0] push_data, head_data;

   // request classification
   lhbp_front #(
      .MAX_INDEX_BITS (MAX_INDEX_BITS),
      .ADDRESS_BITS   (ADDRESS_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_branch_address (req_branch_address),
      .req_taken          (req_taken),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .q_status           (q_status),
      .clearing           (clearing),
      .push               (push),
      .push_data          (push_data)
   );

   // decoupling queue
   lhbp_queue #(
      .WIDTH (MAX_INDEX_BITS + 1),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (q_status)
   );

   // table update and result
   lhbp_back #(
      .MAX_INDEX_BITS (MAX_INDEX_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head_data           (head_data),
      .q_status            (q_status),
      .pop                 (pop),
      .clearing            (clearing),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_predicted_taken (rsp_predicted_taken),
      .rsp_mispredicted    (rsp_mispredicted),
      .rsp_entry_index     (rsp_entry_index),
      .rsp_history_before  (rsp_history_before),
      .rsp_counter_before  (rsp_counter_before),
      .rsp_counter_after   (rsp_counter_after)
   );

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the local history branch predictor. Resolved
// branches go in through the request channel under several index widths and
// idle patterns; a scoreboard keeps its own history and counter tables and
// checks every result transaction field by field, in order.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lhbp_pkg::*;

   localparam int INDEX_W        = DEF_MAX_INDEX_BITS;
   localparam int ADDR_W         = DEF_ADDRESS_BITS;
   localparam int ENTRIES        = 1 << INDEX_W;
   localparam int HOT_BRANCHES   = 6;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 80;
   localparam int HOLD_OFF       = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [CTR_W-1:0] WEAK_TAKEN = 2'd2;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum int {PAT_ALWAYS, PAT_NEVER, PAT_ALTERNATE, PAT_LOOP, PAT_RANDOM} pattern_type;

   typedef struct packed {
      logic               predicted_taken;
      logic               mispredicted;
      logic [INDEX_W-1:0] entry_index;
      logic [HIST_W-1:0]  history_before;
      logic [CTR_W-1:0]   counter_before;
      logic [CTR_W-1:0]   counter_after;
   } prediction_type;

   // scoreboard: private copy of the history and counter tables
   class prediction_scoreboard;
      logic [HIST_W-1:0] history_mem [ENTRIES];
      logic [CTR_W-1:0]  counter_mem [ENTRIES*NUM_CTRS];
      logic [CFG_W-1:0]  index_bits;
      prediction_type    expected_q [$];
      int                failures;

      function new();
         foreach (history_mem[i]) history_mem[i] = '0;
         foreach (counter_mem[i]) counter_mem[i] = '0;
         index_bits = CFG_RESET;
         failures   = 0;
      endfunction

      function string show(prediction_type p);
         return $sformatf("pred=%0b mis=%0b entry=%0d hist=%0d ctr=%0d->%0d",
                          p.predicted_taken, p.mispredicted, p.entry_index,
                          p.history_before, p.counter_before, p.counter_after);
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction

      // accepted branch: predict, then update the tables
      function void note_branch(logic [ADDR_W-1:0] addr, logic tk);
         int                 used_bits;
         int                 mask;
         int                 slot;
         logic [INDEX_W-1:0] entry;
         prediction_type     p;
         used_bits = (index_bits > INDEX_W) ? INDEX_W : index_bits;
         mask      = (1 << used_bits) - 1;
         entry     = INDEX_W'(addr >> ADDR_SHIFT) & mask[INDEX_W-1:0];
         slot      = entry * NUM_CTRS + history_mem[entry];
         p.entry_index     = entry;
         p.history_before  = history_mem[entry];
         p.counter_before  = counter_mem[slot];
         p.predicted_taken = (p.counter_before >= WEAK_TAKEN);
         p.mispredicted    = (p.predicted_taken != tk);
         p.counter_after   = p.counter_before;
         // saturating step of the selected counter
         if (tk && p.counter_before != CTR_MAX) begin
            p.counter_after = p.counter_before + 1'b1;
         end else if (!tk && p.counter_before != CTR_MIN) begin
            p.counter_after = p.counter_before - 1'b1;
         end
         counter_mem[slot]  = p.counter_after;
         history_mem[entry] = {p.history_before[HIST_W-2:0], tk};
         expected_q.push_back(p);
      endfunction

      // result transaction against the oldest expectation
      function void check_prediction(prediction_type got);
         prediction_type want;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected result at %0t: %s", $realtime, show(got));
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("mismatch at %0t: expected %s, actual %s",
                           $realtime, show(want), show(got));
            end
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [ADDR_W-1:0]   req_branch_address = '0;
   logic                req_taken = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_predicted_taken;
   logic                rsp_mispredicted;
   logic [INDEX_W-1:0]  rsp_entry_index;
   logic [HIST_W-1:0]   rsp_history_before;
   logic [CTR_W-1:0]    rsp_counter_before;
   logic [CTR_W-1:0]    rsp_counter_after;
   logic                csr_wr_en = 1'b0;
   logic [CFG_W-1:0]    csr_wr_data = '0;

   prediction_scoreboard sb;
   int                   send_idle_pct = 0;
   int                   recv_stall_pct = 0;
   int                   hold_cycles = 0;
   int                   quiet_cycles = 0;
   logic [CFG_W-1:0]     phase_cfg [PHASES] = '{4'd10, 4'd0, 4'd15, 4'd1, 4'd7, 4'd3, 4'd11, 4'd5};

   local_history_branch_predictor_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_branch_address  (req_branch_address),
      .req_taken           (req_taken),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_predicted_taken (rsp_predicted_taken),
      .rsp_mispredicted    (rsp_mispredicted),
      .rsp_entry_index     (rsp_entry_index),
      .rsp_history_before  (rsp_history_before),
      .rsp_counter_before  (rsp_counter_before),
      .rsp_counter_after   (rsp_counter_after),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: long hold-off when asked, else random stalls
   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // result transaction check
   always @(posedge clock) begin
      prediction_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.predicted_taken = rsp_predicted_taken;
         got.mispredicted    = rsp_mispredicted;
         got.entry_index     = rsp_entry_index;
         got.history_before  = rsp_history_before;
         got.counter_before  = rsp_counter_before;
         got.counter_after   = rsp_counter_after;
         sb.check_prediction(got);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("tb: FAIL");
         $finish;
      end
   end

   function automatic void set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 73; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 73; end
         default:       begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
   endfunction

   // one branch transaction, valid held until accepted
   task automatic send_branch(input logic [ADDR_W-1:0] addr, input logic tk);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_branch_address <= addr;
      req_taken          <= tk;
      do @(posedge clock); while (!req_ready);
      sb.note_branch(addr, tk);
   endtask

   // drop valid and wait for every expected result
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_index_bits(input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.index_bits = value;
   endtask

   // mostly a few hot branches with typical outcome patterns, some noise
   task automatic run_random_phase(input int count);
      logic [ADDR_W-1:0] hot_addr [HOT_BRANCHES];
      pattern_type       pattern [HOT_BRANCHES];
      int                visits [HOT_BRANCHES];
      int                k;
      logic [ADDR_W-1:0] addr;
      logic              tk;
      for (int i = 0; i < HOT_BRANCHES; i++) begin
         hot_addr[i] = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
         pattern[i]  = pattern_type'($urandom_range(PAT_ALWAYS, PAT_RANDOM));
         visits[i]   = 0;
      end
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 75) begin
            k    = $urandom_range(0, HOT_BRANCHES - 1);
            addr = hot_addr[k];
            case (pattern[k])
               PAT_ALWAYS:    tk = 1'b1;
               PAT_NEVER:     tk = 1'b0;
               PAT_ALTERNATE: tk = visits[k][0];
               PAT_LOOP:      tk = (visits[k] % 4 != 3);
               default:       tk = 1'($urandom_range(0, 1));
            endcase
            visits[k]++;
         end else begin
            addr = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
            tk   = 1'($urandom_range(0, 1));
         end
         send_branch(addr, tk);
      end
   endtask

   // main sequence
   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset width of 3: saturate up on one entry, down on the top entry
      set_idling(IDLE_NONE);
      repeat (6) send_branch(12'h000, 1'b1);
      send_branch(12'hFFF, 1'b0);
      send_branch(12'hFFF, 1'b0);
      send_branch(12'h020, 1'b0);   // aliases onto entry 0
      wait_drained();

      // zero index bits: one shared entry
      write_index_bits(4'd0);
      send_branch(12'hFFF, 1'b1);
      send_branch(12'h7FC, 1'b0);
      send_branch(12'h004, 1'b1);
      send_branch(12'h000, 1'b1);
      wait_drained();

      // width above the table size clamps to the full index
      write_index_bits(4'd15);
      send_branch(12'hFFF, 1'b1);
      send_branch(12'hFFF, 1'b1);
      send_branch(12'hFFC, 1'b0);
      send_branch(12'h004, 1'b1);
      send_branch(12'h800, 1'b0);
      wait_drained();

      // random phases over widths and idle patterns
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1)
            write_index_bits(CFG_W'($urandom_range(0, (1 << CFG_W) - 1)));
         else
            write_index_bits(phase_cfg[p]);
         set_idling(idle_mode_type'(p % 4));
         // receiver holds off while the sender keeps offering
         if (p == 4)
            hold_cycles = HOLD_OFF;
         run_random_phase(PHASE_ITEMS);
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("tb: PASS");
      end else begin
         if (sb.outstanding() != 0)
            $display("%0d expected results never arrived", sb.outstanding());
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

@@ local_history_branch_predictor_top.f @@
sv/lhbp_pkg.sv
sv/lhbp_ram.sv
sv/lhbp_queue.sv
sv/lhbp_front.sv
sv/lhbp_back.sv
sv/local_history_branch_predictor_top.sv
test/tb.sv
